FILE: hw/rtl/fqrr_pkg.sv
// Shared constants and types for the four-queue round-robin drain block.
`default_nettype none

package fqrr_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH     = 16;
  localparam int NUM_QUEUES      = 4;
  localparam int QSEL_W          = 2;
  localparam int SLOTS_PER_QUEUE = 16;
  localparam int SLOT_W          = 4;
  localparam int TAG_W           = 64;
  localparam int TAG_DEPTH       = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int ADDR_W          = QSEL_W + SLOT_W;

  // Counter widths
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W   = FILL_W + 1;
  localparam int TOTAL_W = FILL_W + 2;

  typedef enum logic [0:0] {
    OP_ENQUEUE = 1'b0,
    OP_DRAIN   = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/fqrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fqrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port: data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/four_queue_round_robin_drain_top.sv
// Top level: four tag queues in one RAM, drained round robin.
//
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+--------------------------------------
// in      | input     | in_valid_i/in_stall_o | opcode_i, queue_select_i, tag_value_i
// out     | output    | out_valid_o/out_stall_i | out_tag_o, source_queue_o, last_result_o
//
// An enqueue to a queue that is not full is one write to the tag RAM.
// A drain of N stored tags keeps the input stalled until its last RAM read issues, one
// read per cycle while the output is not stalled; the single read port sets that rate.
// Tags pass the RAM read register, then the output register. An empty drain never stalls.
// Reset clears head and fill counters at once; the RAM needs no clearing pass.
// Output stalls back up into the read issue, which pauses until the output frees.
`default_nettype none

module four_queue_round_robin_drain_top
  import fqrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [0:0]        opcode_i,
  input  wire logic [QSEL_W-1:0] queue_select_i,
  input  wire logic [TAG_W-1:0]  tag_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [TAG_W-1:0]       out_tag_o,
  output logic [QSEL_W-1:0]      source_queue_o,
  output logic                   last_result_o
);

  state_e              state_q, state_d;
  logic [QSEL_W-1:0]   rr_q, rr_d;
  logic [SLOT_W-1:0]   head_q [NUM_QUEUES];
  logic [FILL_W-1:0]   fill_q [NUM_QUEUES];

  logic                pend_q;
  logic [QSEL_W-1:0]   pend_src_q;
  logic                pend_last_q;
  logic                out_valid_q;
  logic [TAG_W-1:0]    out_tag_q;
  logic [QSEL_W-1:0]   out_src_q;
  logic                out_last_q;

  logic                in_accept;
  logic                enq_accept;
  logic                drain_accept;
  logic                enq_full;
  logic                enq_write;
  logic [POS_W-1:0]    tail_sum;
  logic [POS_W-1:0]    tail_pos;
  logic [ADDR_W-1:0]   wr_addr;

  logic                sel_found;
  logic [QSEL_W-1:0]   sel_queue;
  logic [TOTAL_W-1:0]  total;
  logic                issue;
  logic                issue_last;
  logic                advance;
  logic                can_issue;
  logic [ADDR_W-1:0]   rd_addr;
  logic [TAG_W-1:0]    rd_data;

  // Input handshake decode
  assign in_accept    = in_valid_i && !in_stall_o;
  assign enq_accept   = in_accept && (opcode_i == OP_ENQUEUE);
  assign drain_accept = in_accept && (opcode_i == OP_DRAIN);

  // Tail slot of the target queue: (head + fill) mod depth, sum below twice the depth
  assign enq_full = (fill_q[queue_select_i] == FILL_W'(QUEUE_DEPTH));
  assign enq_write = enq_accept && !enq_full;
  assign tail_sum = POS_W'(head_q[queue_select_i]) + POS_W'(fill_q[queue_select_i]);
  assign tail_pos = (tail_sum >= POS_W'(QUEUE_DEPTH)) ? tail_sum - POS_W'(QUEUE_DEPTH)
                                                      : tail_sum;
  assign wr_addr  = {queue_select_i, tail_pos[SLOT_W-1:0]};

  // Total tags stored across all queues
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      total = total + TOTAL_W'(fill_q[i]);
    end
  end

  // Pick the first non-empty queue at or after the round-robin pointer
  always_comb begin
    logic [QSEL_W-1:0] cand;
    sel_found = 1'b0;
    sel_queue = rr_q;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      cand = rr_q + QSEL_W'(k);
      if (!sel_found && (fill_q[cand] != '0)) begin
        sel_found = 1'b1;
        sel_queue = cand;
      end
    end
  end

  // Output stage frees when empty or taken; a read may issue once the pending slot frees
  assign advance    = !out_valid_q || !out_stall_i;
  assign can_issue  = !pend_q || advance;
  assign issue_last = (total == TOTAL_W'(1));
  assign rd_addr    = {sel_queue, head_q[sel_queue]};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (drain_accept && (total != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue && issue_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b0;
    issue      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        issue      = 1'b0;
      end
      ST_DRAIN: begin
        in_stall_o = 1'b1;
        issue      = sel_found && can_issue;
      end
      default: begin
        in_stall_o = 1'b1;
        issue      = 1'b0;
      end
    endcase
  end

  // Round-robin pointer: restart at queue 0 on each drain, move past the served queue
  always_comb begin
    rr_d = rr_q;
    if (drain_accept) begin
      rr_d = '0;
    end else if (issue) begin
      rr_d = sel_queue + QSEL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rr_q    <= '0;
    end else begin
      state_q <= state_d;
      rr_q    <= rr_d;
    end
  end

  // Raise fill on each enqueue write; on each read issue lower fill and advance head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (enq_write) begin
      fill_q[queue_select_i] <= fill_q[queue_select_i] + FILL_W'(1);
    end else if (issue) begin
      fill_q[sel_queue] <= fill_q[sel_queue] - FILL_W'(1);
      head_q[sel_queue] <= (head_q[sel_queue] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                           : head_q[sel_queue] + SLOT_W'(1);
    end
  end

  // Tag storage
  fqrr_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (enq_write),
    .wr_addr_i (wr_addr),
    .wr_data_i (tag_value_i),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Track the read in flight and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        pend_q <= 1'b1;
      end else if (advance) begin
        pend_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= pend_q;
      end
    end
  end

  // Hold transaction payload alongside the control bits
  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_src_q  <= sel_queue;
      pend_last_q <= issue_last;
    end
    if (advance && pend_q) begin
      out_tag_q  <= rd_data;
      out_src_q  <= pend_src_q;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_tag_o      = out_tag_q;
  assign source_queue_o = out_src_q;
  assign last_result_o  = out_last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fqrr_checker.sv
// Port-level checks for the drain block, bound to the top level.
`default_nettype none

module fqrr_checker
  import fqrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_o,
  input  wire logic [0:0]        opcode_i,
  input  wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  input  wire logic [TAG_W-1:0]  out_tag_o,
  input  wire logic [QSEL_W-1:0] source_queue_o,
  input  wire logic              last_result_o
);

  // A stalled result transaction stays up and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_tag_o)
      && $stable(source_queue_o) && $stable(last_result_o))
    else $error("stalled result transaction changed");

  // An accepted enqueue leaves the input open in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_ENQUEUE) |=> !in_stall_o)
    else $error("input stalled after an enqueue");

  // The input only stalls right after an accepted drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o && (opcode_i == OP_DRAIN)))
    else $error("input stall rose without a drain");

endmodule

bind four_queue_round_robin_drain_top fqrr_checker u_fqrr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_tag_o      (out_tag_o),
  .source_queue_o (source_queue_o),
  .last_result_o  (last_result_o)
);

`default_nettype wire
